>>> sv/smpq_pkg.sv
// shared types and constants for the sorted minimum priority queue
package smpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned ENTRY_COUNT_W = 5;

  localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POLL = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_PEEK = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } smpq_cmd_t;

endpackage

>>> sv/smpq_ctrl.sv
// controller state machine: accepts a transaction, runs an execute state, strobes done
module smpq_ctrl
  import smpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output smpq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic done_next;

  always_comb begin
    state_next = state;
    done_next = 1'b0;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
    end
  end

  assign busy = (state == S_EXEC);

endmodule

>>> sv/smpq_datapath.sv
// datapath: sorted entry cells with parallel compare and shift, count and result registers
module smpq_datapath
  import smpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  smpq_cmd_t                   cmd,
  input  logic [ACTION_W-1:0]         action,
  input  logic signed [VALUE_W-1:0]   value,
  output logic signed [VALUE_W-1:0]   out_value,
  output logic                        found,
  output logic                        overflow,
  output logic [ENTRY_COUNT_W-1:0]    entry_count
);

  localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

  logic [ACTION_W-1:0] act_q;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] entries [CAPACITY];
  logic signed [VALUE_W-1:0] entries_next [CAPACITY];
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [CAPACITY-1:0] shift;
  logic is_full;
  logic no_entries;
  logic do_add;
  logic do_poll;
  logic do_read;
  logic [COUNT_W+ENTRY_COUNT_W-1:0] count_ext;

  assign is_full = (count == COUNT_W'(CAPACITY));
  assign no_entries = (count == '0);
  assign do_add = (act_q == ACT_ADD) && !is_full;
  assign do_poll = (act_q == ACT_POLL) && !no_entries;
  assign do_read = ((act_q == ACT_POLL) || (act_q == ACT_PEEK)) && !no_entries;

  // cell i moves up when its value is greater than the new one or it is unused
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      shift[i] = (COUNT_W'(i) >= count) || (val_q < entries[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_next[i] = entries[i];
    end
    if (do_add) begin
      if (shift[0]) begin
        entries_next[0] = val_q;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (shift[i]) begin
          entries_next[i] = shift[i-1] ? entries[i-1] : val_q;
        end
      end
    end else if (do_poll) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        entries_next[i] = entries[i+1];
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_add) begin
      count_next = count + COUNT_W'(1);
    end else if (do_poll) begin
      count_next = count - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      val_q <= value;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries[i] <= entries_next[i];
      end
      out_value <= do_read ? entries[0] : '0;
      found <= do_read;
      overflow <= (act_q == ACT_ADD) && is_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  assign count_ext = {{ENTRY_COUNT_W{1'b0}}, count};
  assign entry_count = count_ext[ENTRY_COUNT_W-1:0];

endmodule

>>> sv/sorted_min_priority_queue.sv
// top level of the sorted minimum priority queue
// Holds up to CAPACITY signed 32-bit values in ascending order; equal values leave in
// arrival order. A transaction is taken when start is high and busy is low; action 0
// adds value, 1 polls the smallest, 2 peeks at it. In each transaction the command is
// captured at the accepting edge, then in the execute state every cell compares
// against the new value and shifts in parallel, and the result and done are registered.
// done is high for exactly one cycle with the result, and the next transaction may be
// accepted at the edge that ends it.
// The receiver cannot stall: results must be taken while done is high.
// entry_count reports the low five bits of the count after the transaction.
module sorted_min_priority_queue
  import smpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ACTION_W-1:0]         action,
  input  logic signed [VALUE_W-1:0]   value,
  output logic                        done,
  output logic signed [VALUE_W-1:0]   out_value,
  output logic                        found,
  output logic                        overflow,
  output logic [ENTRY_COUNT_W-1:0]    entry_count
);

  smpq_cmd_t cmd;

  smpq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .action      (action),
    .value       (value),
    .out_value   (out_value),
    .found       (found),
    .overflow    (overflow),
    .entry_count (entry_count)
  );

endmodule

>>> test/tb.sv
// self-checking testbench for the sorted minimum priority queue
`timescale 1ns / 100ps

module tb;
  import smpq_pkg::*;

  localparam int CAPACITY = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic found;
    logic overflow;
    logic [ENTRY_COUNT_W-1:0] count;
  } pq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [ACTION_W-1:0] action = ACT_ADD;
  logic signed [VALUE_W-1:0] value = '0;
  logic busy;
  logic done;
  logic signed [VALUE_W-1:0] out_value;
  logic found;
  logic overflow;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  logic signed [VALUE_W-1:0] sorted_model[$];
  pq_result_t pending_results[$];
  int err_count = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;

  sorted_min_priority_queue #(.CAPACITY(CAPACITY)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .value(value),
    .done(done),
    .out_value(out_value),
    .found(found),
    .overflow(overflow),
    .entry_count(entry_count)
  );

  always #6 clk = ~clk;

  function automatic pq_result_t apply_queue_op(logic [ACTION_W-1:0] act,
                                                logic signed [VALUE_W-1:0] val);
    pq_result_t r;
    int pos;
    r.value = '0;
    r.found = 1'b0;
    r.overflow = 1'b0;
    case (act)
      ACT_ADD: begin
        if (sorted_model.size() >= CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          pos = sorted_model.size();
          for (int i = 0; i < sorted_model.size(); i++) begin
            if (val < sorted_model[i]) begin
              pos = i;
              break;
            end
          end
          sorted_model.insert(pos, val);
        end
      end
      ACT_POLL: begin
        if (sorted_model.size() > 0) begin
          r.value = sorted_model.pop_front();
          r.found = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (sorted_model.size() > 0) begin
          r.value = sorted_model[0];
          r.found = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.count = ENTRY_COUNT_W'(sorted_model.size());
    return r;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = VALUE_MAX;
          1: v = VALUE_MIN;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = VALUE_W'(int'($urandom_range(0, 8)) - 4);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_op(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
    start <= 1'b1;
    action <= act;
    value <= val;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_queue_op(act, val));
    if (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      start <= 1'b0;
      action <= ACTION_W'($urandom);
      value <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_op(ACT_POLL, VALUE_MAX);
    send_op(ACT_PEEK, VALUE_MIN);
    send_op(ACT_UNUSED, -1);
  endtask

  task automatic test_fill_and_overflow();
    logic signed [VALUE_W-1:0] fill_vals[16];
    fill_vals = '{VALUE_MAX, VALUE_MIN, 0, -1, 1, 0, 0, -1, VALUE_MAX, VALUE_MIN,
                  7, -7, 100, -100, 32'sh40000000, 5};
    foreach (fill_vals[i]) send_op(ACT_ADD, fill_vals[i]);
    send_op(ACT_ADD, 3);
    send_op(ACT_PEEK, 0);
    send_op(ACT_UNUSED, 0);
    send_op(ACT_POLL, -1);
  endtask

  task automatic test_random_traffic(int n, int idle_pct);
    int mode;
    int roll;
    int add_limit;
    logic [ACTION_W-1:0] act;
    mode = 0;
    sender_idle_pct = idle_pct;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) mode = $urandom_range(0, 2);
      add_limit = (mode == 0) ? 75 : (mode == 1) ? 30 : 54;
      roll = $urandom_range(1, 100);
      if (roll <= 3) act = ACT_UNUSED;
      else if (roll <= 8) act = ACT_PEEK;
      else if (roll <= add_limit) act = ACT_ADD;
      else act = ACT_POLL;
      send_op(act, random_value());
    end
    sender_idle_pct = 0;
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 6; k++) send_op(ACT_ADD, random_value());
    wait_until_drained();
    send_op(ACT_PEEK, 0);
    send_op(ACT_POLL, 0);
  endtask

  // result checker
  always @(posedge clk) begin
    pq_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction out_value", out_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (overflow !== want.overflow) report_mismatch("overflow", overflow, want.overflow);
        if (entry_count !== want.count) report_mismatch("entry_count", entry_count, want.count);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_fill_and_overflow();
    test_random_traffic(160, 0);
    test_drain_pause();
    test_random_traffic(160, 67);
    test_random_traffic(160, 26);
    wait_until_drained();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
